@@ rtl/touch_frame_parser_assert.svh @@
// Assertion macros for the touch frame parser.
`ifndef TOUCH_FRAME_PARSER_ASSERT_SVH
`define TOUCH_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch_frame_parser: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch_frame_parser: next-cycle check failed");

`endif

@@ rtl/tfp_pkg.sv @@
package tfp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2,
		PH_SUM  = 2'd3
	} phase_t;

	localparam logic [7:0] START_BYTE = 8'hF0;
	localparam logic [7:0] HDR_B0     = 8'h00;
	localparam logic [7:0] HDR_B1     = 8'h0C;
	localparam logic [7:0] HDR_B2     = 8'h01;
	localparam int         HEAD_N     = 8;

	typedef struct packed {
		logic        touched;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
	} report_t;

endpackage

@@ rtl/tfp_byte_if.sv @@
interface tfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/tfp_report_if.sv @@
interface tfp_report_if;
	logic        valid;
	logic        ready;
	logic        touched;
	logic [15:0] x_pos;
	logic [15:0] y_pos;

	modport source (output valid, output touched, output x_pos, output y_pos, input ready);
	modport sink (input valid, input touched, input x_pos, input y_pos, output ready);
endinterface

@@ rtl/touch_frame_parser.sv @@
// Channel   Dir  Payload                    Meaning
// rx        in   rx_byte[7:0]               one received serial byte per word
// report    out  touched, x_pos, y_pos      one touch report per valid frame
//
// Path: a byte waits in the input register, and the report word built from
// the frame leaves from the output register.
// Throughput: one byte per cycle while report.ready is high; the frame state
// update and checksum compare fit between the two registers.
// Reset (arst_n low) returns the parser to idle with cleared header bytes.
// A report not taken holds the output register; the input register still
// accepts one more byte, after which rx.ready drops until the report leaves.
module touch_frame_parser
	import tfp_pkg::*;
#(
	parameter int MAX_FRAME = 48
) (
	input  logic clk,
	input  logic arst_n,
	tfp_byte_if.sink     rx,
	tfp_report_if.source report
);

`include "touch_frame_parser_assert.svh"

	// count must hold any accepted length, i.e. up to MAX_FRAME-1
	localparam int CNT_W = $clog2(MAX_FRAME);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	phase_t               phase_q, phase_d;
	logic [CNT_W-1:0]     len_q, len_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W:0]       cnt_inc;
	logic [7:0]           sum_q, sum_d;
	logic [HEAD_N-1:0][7:0] head_q, head_d;

	// output stage
	logic    out_valid_q;
	report_t report_q, report_d;
	logic    report_load;

	logic out_free;
	logic take;
	logic len_ok;
	logic frame_ok;

	assign out_free = !out_valid_q || report.ready;
	assign take     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	assign len_ok   = {1'b0, byte_s1} < 9'(MAX_FRAME);
	assign cnt_inc  = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
	assign frame_ok = (byte_s1 == sum_q) && (head_q[0] == HDR_B0) &&
		(head_q[1] == HDR_B1) && (head_q[2] == HDR_B2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == START_BYTE) phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (!len_ok) phase_d = PH_IDLE;
				else if (byte_s1 == 8'h00) phase_d = PH_SUM;
				else phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (cnt_inc >= {1'b0, len_q}) phase_d = PH_SUM;
			end
			PH_SUM: begin
				phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// datapath per phase
	always_comb begin
		len_d       = len_q;
		cnt_d       = cnt_q;
		sum_d       = sum_q;
		head_d      = head_q;
		report_load = 1'b0;
		report_d    = '0;
		case (phase_q)
			PH_IDLE: begin
			end
			PH_LEN: begin
				cnt_d = '0;
				if (len_ok) begin
					len_d  = byte_s1[CNT_W-1:0];
					sum_d  = byte_s1;
					head_d = '0;
				end else begin
					len_d = '0;
				end
			end
			PH_DATA: begin
				if (cnt_q < CNT_W'(HEAD_N)) head_d[cnt_q[2:0]] = byte_s1;
				sum_d = sum_q + byte_s1;
				cnt_d = cnt_inc[CNT_W-1:0];
			end
			PH_SUM: begin
				if (frame_ok) begin
					report_load = 1'b1;
					if (head_q[3] != 8'h00) begin
						report_d.touched = 1'b1;
						report_d.x_pos   = {head_q[5], head_q[4]};
						report_d.y_pos   = {head_q[7], head_q[6]};
					end
				end
				len_d  = '0;
				cnt_d  = '0;
				sum_d  = '0;
				head_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			head_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			head_q  <= head_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take && report_load;
		end
	end

	always_ff @(posedge clk) begin
		if (take && report_load) begin
			report_q <= report_d;
		end
	end

	assign report.valid   = out_valid_q;
	assign report.touched = report_q.touched;
	assign report.x_pos   = report_q.x_pos;
	assign report.y_pos   = report_q.y_pos;

	// a report is only ever raised by a checksum byte
	`TFP_ASSERT_NOW(a_report_from_sum, clk, arst_n, take && report_load, phase_q == PH_SUM)
	// payload count stays below the frame length
	`TFP_ASSERT_NOW(a_cnt_below_len, clk, arst_n, phase_q == PH_DATA, cnt_q < len_q)
	// checksum byte always closes the frame
	`TFP_ASSERT_NEXT(a_sum_to_idle, clk, arst_n, take && phase_q == PH_SUM,
		phase_q == PH_IDLE)
	// header store is clear whenever no frame is open
	`TFP_ASSERT_NOW(a_idle_head_clear, clk, arst_n, phase_q == PH_IDLE, head_q == '0)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import tfp_pkg::*;

	// Length bytes at or above this drop the frame.
	localparam int FRAME_LIMIT = 48;
	// Cycles with no word moving on either channel before the run is abandoned.
	// The long receiver hold is far shorter than this.
	localparam int QUIET_LIMIT = 5000;
	// Length of the forced receiver hold used to back the parser up.
	localparam int LONG_HOLD   = 400;
	// Random bytes offered in each idling phase.
	localparam int PHASE_BYTES = 275;

	// Shadow decoder: mirrors the parser's frame state byte by byte and queues
	// the touch report each frame should yield, in order.
	class touch_report_board;
		phase_t      state;
		logic [5:0]  frame_len;
		logic [5:0]  byte_count;
		logic [7:0]  running_sum;
		logic [7:0]  head [HEAD_N];
		report_t     reports_due[$];
		int unsigned errors;

		function new();
			state = PH_IDLE;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			frame_len = '0;
			byte_count = '0;
			running_sum = '0;
			foreach (head[i]) head[i] = '0;
		endfunction

		// One accepted rx word.
		function void take_byte(logic [7:0] b);
			report_t r;
			case (state)
				PH_IDLE: begin
					if (b == START_BYTE)
						state = PH_LEN;
				end
				PH_LEN: begin
					if (b < FRAME_LIMIT) begin
						clear_frame();
						frame_len = b[5:0];
						running_sum = b;
						state = (b == 8'd0) ? PH_SUM : PH_DATA;
					end else begin
						frame_len = '0;
						byte_count = '0;
						state = PH_IDLE;
					end
				end
				PH_DATA: begin
					if (byte_count < HEAD_N)
						head[byte_count[2:0]] = b;
					running_sum = running_sum + b;
					byte_count = byte_count + 6'd1;
					if (byte_count >= frame_len)
						state = PH_SUM;
				end
				default: begin
					if (b == running_sum && head[0] == HDR_B0 && head[1] == HDR_B1 &&
							head[2] == HDR_B2) begin
						r.touched = (head[3] != 8'h00);
						r.x_pos = r.touched ? {head[5], head[4]} : 16'h0000;
						r.y_pos = r.touched ? {head[7], head[6]} : 16'h0000;
						reports_due.push_back(r);
					end
					state = PH_IDLE;
					clear_frame();
				end
			endcase
		endfunction

		// One accepted report word against the oldest pending report.
		function void check_report(logic touched, logic [15:0] x_pos, logic [15:0] y_pos);
			report_t want;
			if (reports_due.size() == 0) begin
				$error("report word with none pending: touched %0d x %0d y %0d",
					touched, x_pos, y_pos);
				errors++;
				return;
			end
			want = reports_due.pop_front();
			if (touched !== want.touched) begin
				$error("touched: expected %0d, got %0d", want.touched, touched);
				errors++;
			end
			if (x_pos !== want.x_pos) begin
				$error("x_pos: expected %0d, got %0d", want.x_pos, x_pos);
				errors++;
			end
			if (y_pos !== want.y_pos) begin
				$error("y_pos: expected %0d, got %0d", want.y_pos, y_pos);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tfp_byte_if   rx_if ();
	tfp_report_if rep_if ();

	touch_frame_parser #(
		.MAX_FRAME(FRAME_LIMIT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.report (rep_if)
	);

	touch_report_board sb;

	int unsigned src_idle_pct;   // chance, per cycle, that the sender holds back
	int unsigned sink_stall_pct; // chance, per cycle, that the receiver drops ready
	bit          hold_req;       // asks the receiver process for one long hold
	int unsigned hold_left;
	int unsigned bytes_sent;
	int unsigned quiet_cycles;
	logic [7:0]  body[$];        // payload of the frame being built

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus the long hold counted here so the
	// sender keeps offering bytes while the parser fills and stalls rx.
	initial begin
		rep_if.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				rep_if.ready <= 1'b0;
			end else begin
				rep_if.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Both channels watched at the edge; the byte goes in first so that a
	// report moving in the same cycle is still matched in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				sb.take_byte(rx_if.rx_byte);
			if (rep_if.valid && rep_if.ready)
				sb.check_report(rep_if.touched, rep_if.x_pos, rep_if.y_pos);
		end
	end

	// Watchdog: too long with nothing moving means the parser has hung.
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (rep_if.valid && rep_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one byte, with random idle cycles ahead of it; returns at the
	// edge where the word is taken. Ready is looked at on the falling edge,
	// where it is settled for the coming rising edge.
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(negedge clk); while (!rx_if.ready);
		@(posedge clk);
		bytes_sent++;
	endtask

	// Start, length, payload from body, then the checksum xored with sum_flip
	// (nonzero flip gives a bad checksum).
	task automatic send_frame(input logic [7:0] n, input logic [7:0] sum_flip);
		logic [7:0] sum;
		sum = n;
		foreach (body[i]) sum = sum + body[i];
		put_byte(START_BYTE);
		put_byte(n);
		foreach (body[i]) put_byte(body[i]);
		put_byte(sum ^ sum_flip);
	endtask

	// Touch payload cut or padded with random bytes to n.
	task automatic build_touch_body(input bit press, input logic [15:0] x,
			input logic [15:0] y, input int unsigned n);
		logic [7:0] lift;
		lift = press ? 8'($urandom_range(1, 255)) : 8'h00;
		body = {HDR_B0, HDR_B1, HDR_B2, lift, x[7:0], x[15:8], y[7:0], y[15:8]};
		while (body.size() > n) void'(body.pop_back());
		while (body.size() < n) body.push_back(8'($urandom));
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed touch frames with random content, mixed with broken
	// ones and noise.
	task automatic run_random(input int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		int unsigned k;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// touch frame, long ones now and then, one bad checksum in ten
				n = ($urandom_range(9) == 0) ? $urandom_range(9, FRAME_LIMIT - 1)
					: $urandom_range(3, 8);
				build_touch_body($urandom_range(3) != 0, pick_coord(), pick_coord(), n);
				send_frame(8'(n),
					($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
			end else if (pick < 70) begin
				// wrong header, good checksum
				n = $urandom_range(3, 8);
				build_touch_body(1'($urandom_range(1)), pick_coord(), pick_coord(), n);
				k = $urandom_range(2);
				body[k] = body[k] ^ 8'($urandom_range(1, 255));
				send_frame(8'(n), 8'h00);
			end else if (pick < 78) begin
				// arbitrary payload, empty included
				n = ($urandom_range(3) == 0) ? $urandom_range(0, FRAME_LIMIT - 1)
					: $urandom_range(0, 8);
				body.delete();
				repeat (n) body.push_back(8'($urandom));
				send_frame(8'(n), 8'h00);
			end else if (pick < 88) begin
				// line noise; an odd start byte in it is fine
				repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
			end else if (pick < 95) begin
				put_byte(START_BYTE);
				put_byte(8'($urandom_range(FRAME_LIMIT, 255)));
			end else begin
				// frame cut short; following bytes land in its payload
				n = $urandom_range(4, 20);
				put_byte(START_BYTE);
				put_byte(8'(n));
				repeat ($urandom_range(0, n - 1)) put_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 1'b0;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle noise at both ends of the byte range
		put_byte(8'h00);
		put_byte(8'hFF);
		// start byte as its own length, then the first oversized length
		put_byte(START_BYTE);
		put_byte(START_BYTE);
		put_byte(START_BYTE);
		put_byte(8'(FRAME_LIMIT));
		// empty payload: length straight into checksum, no report
		body.delete();
		send_frame(8'd0, 8'h00);
		// three-byte header only: lift byte missing reads as zero, so release
		build_touch_body(1'b1, 16'hFFFF, 16'hFFFF, 3);
		send_frame(8'd3, 8'h00);
		// full press at the top corner
		build_touch_body(1'b1, 16'hFFFF, 16'hFFFF, 8);
		send_frame(8'd8, 8'h00);

		// No idling, with one long receiver hold at the start
		hold_req = 1'b1;
		run_random(PHASE_BYTES);
		src_idle_pct = 80;
		run_random(PHASE_BYTES);
		src_idle_pct = 0;
		sink_stall_pct = 80;
		run_random(PHASE_BYTES);
		src_idle_pct = 22;
		sink_stall_pct = 22;
		run_random(PHASE_BYTES);

		rx_if.valid <= 1'b0;
		sink_stall_pct = 0;
		while (sb.reports_due.size() != 0) @(posedge clk);
		// let any stray report word surface
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
